// File: rtl/core/pmps_pkg.sv
// Shared types, constants and helper functions for the player movement step.
package pmps_pkg;

  // Request from the sequencer to the root/divide unit
  typedef struct packed {
    logic start;
    logic is_sqrt;
  } ds_req_t;

  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] CFG_MAX_SPEED    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_JUMP_SPEED   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_GRAVITY      = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_FRICTION     = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_GROUND_ACCEL = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_AIR_ACCEL    = 3'd5;

  localparam logic [23:0] RST_MAX_SPEED    = 24'd655360;
  localparam logic [23:0] RST_JUMP_SPEED   = 24'd327680;
  localparam logic [23:0] RST_GRAVITY      = 24'd642908;
  localparam logic [23:0] RST_FRICTION     = 24'd393216;
  localparam logic [23:0] RST_GROUND_ACCEL = 24'd655360;
  localparam logic [23:0] RST_AIR_ACCEL    = 24'd131072;

  // length above 0.01 in Q4.28 squared; speed above 0.01 in Q32.32 squared
  localparam logic signed [65:0] L2_MIN = 66'sd26843;
  localparam logic signed [65:0] S2_MIN = 66'sd429496;

  localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
  localparam logic signed [65:0] SAT_LO = -66'sd2147483648;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    logic signed [31:0] r;
    if (x > SAT_HI) begin
      r = 32'sh7fffffff;
    end else if (x < SAT_LO) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  // arithmetic shift right rounding toward zero
  function automatic logic signed [65:0] trunc_shr(input logic signed [65:0] x,
                                                   input int unsigned sh);
    logic signed [65:0] bias;
    bias = x[65] ? ((66'sd1 <<< sh) - 66'sd1) : 66'sd0;
    return (x + bias) >>> sh;
  endfunction

endpackage

// File: rtl/core/pmps_mul.sv
// Shared signed 33x33 multiplier with registered product.
module pmps_mul (
  input  logic               clk,
  input  logic signed [32:0] a,
  input  logic signed [32:0] b,
  output logic signed [65:0] prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

endmodule

// File: rtl/core/pmps_divsqrt.sv
// Iterative unit: 64/32 unsigned divide or 64-bit integer square root, one bit a cycle.
module pmps_divsqrt (
  input  logic                    clk,
  input  logic                    rst_n,
  input  pmps_pkg::ds_req_t       req,
  input  logic [63:0]             opa,
  input  logic [31:0]             opb,
  output logic                    done,
  output logic [31:0]             res
);
  import pmps_pkg::*;

  logic        busy_r, done_r, sq_r;
  logic [4:0]  cnt_r;
  logic [33:0] rem_r;
  logic [63:0] rad_r;
  logic [31:0] q_r, b_r;

  logic [35:0] cat_s, trial_s;
  logic [32:0] cat_d;
  logic [33:0] rem_nxt;
  logic        bit_nxt;

  always_comb begin
    cat_s   = {rem_r, rad_r[63:62]};
    trial_s = {2'b00, q_r, 2'b01};
    cat_d   = {rem_r[31:0], rad_r[63]};
    if (sq_r) begin
      bit_nxt = (cat_s >= trial_s);
      rem_nxt = bit_nxt ? 34'(cat_s - trial_s) : cat_s[33:0];
    end else begin
      bit_nxt = (cat_d >= {1'b0, b_r});
      rem_nxt = bit_nxt ? 34'(cat_d - {1'b0, b_r}) : {1'b0, cat_d};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        sq_r   <= req.is_sqrt;
        q_r    <= '0;
        b_r    <= opb;
        if (req.is_sqrt) begin
          rem_r <= '0;
          rad_r <= opa;
        end else begin
          rem_r <= {2'b00, opa[63:32]};
          rad_r <= {opa[31:0], 32'd0};
        end
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        q_r   <= {q_r[30:0], bit_nxt};
        rad_r <= sq_r ? {rad_r[61:0], 2'b00} : {rad_r[62:0], 1'b0};
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign res  = q_r;

endmodule

// File: rtl/core/player_movement_physics_step.sv
// Top level: player movement step sequencer with shared multiplier and root/divide unit.
//
// One input item is one frame tick: time step, five key bits, the flattened
// forward vector, the right vector and the ground flag. One result item
// follows each input item: new position, new velocity (Q16.16, saturated)
// and a jump flag. Position, velocity and the jump-edge memory persist.
// Handshake is valid/stall on both channels; an item moves at a rising edge
// with valid high and stall low. in_stall is high from acceptance until the
// result is loaded into the output register, so one item is in work at a time.
// Work per item is set by the 32-step root/divide unit (up to eight passes
// per item, on the ground with normalizing and friction, none for a short
// wish vector and a slow player) and by the products through the single
// 33x33 multiplier. A new item is taken the cycle after the result loads.
// The output register holds a finished result while out_stall is high; the
// next item may be accepted meanwhile, and its result waits in the sequencer
// until the output register frees up.
// Synchronous reset clears the state to zero, restores register defaults,
// and drops out_valid. Configuration writes are registered; indexes of
// six or more are ignored.
module player_movement_physics_step (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        in_time_step,
  input  logic               in_key_forward,
  input  logic               in_key_back,
  input  logic               in_key_left,
  input  logic               in_key_right,
  input  logic               in_key_jump,
  input  logic signed [15:0] in_fwd_x,
  input  logic signed [15:0] in_fwd_z,
  input  logic signed [15:0] in_side_x,
  input  logic signed [15:0] in_side_y,
  input  logic signed [15:0] in_side_z,
  input  logic               in_grounded,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_pos_z,
  output logic signed [31:0] out_vel_x,
  output logic signed [31:0] out_vel_y,
  output logic signed [31:0] out_vel_z,
  output logic               out_jumped,
  input  logic               cfg_we,
  input  logic [pmps_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [23:0]        cfg_wdata
);
  import pmps_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_L2, S_LEN, S_NRM, S_VSQ, S_SPD, S_K, S_DROP, S_SCL,
    S_GRAV, S_DOT, S_A, S_AS, S_UPD, S_JMP, S_INT, S_DONE
  } state_t;

  // configuration registers
  logic [23:0] max_speed_r, jump_speed_r, gravity_r, friction_r;
  logic [23:0] ground_accel_r, air_accel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_speed_r    <= RST_MAX_SPEED;
      jump_speed_r   <= RST_JUMP_SPEED;
      gravity_r      <= RST_GRAVITY;
      friction_r     <= RST_FRICTION;
      ground_accel_r <= RST_GROUND_ACCEL;
      air_accel_r    <= RST_AIR_ACCEL;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_SPEED:    max_speed_r    <= cfg_wdata;
        CFG_JUMP_SPEED:   jump_speed_r   <= cfg_wdata;
        CFG_GRAVITY:      gravity_r      <= cfg_wdata;
        CFG_FRICTION:     friction_r     <= cfg_wdata;
        CFG_GROUND_ACCEL: ground_accel_r <= cfg_wdata;
        CFG_AIR_ACCEL:    air_accel_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sequencer registers
  state_t state_r, state_nxt;
  logic [1:0] idx_r, idx_nxt, ph_r, ph_nxt;
  logic signed [65:0] acc_r, acc_nxt;
  logic signed [17:0] w_r [3];
  logic signed [17:0] w_nxt [3];
  logic signed [31:0] v_r [3];       // stored velocity
  logic signed [31:0] v_nxt [3];
  logic signed [31:0] p_r [3];       // stored position
  logic signed [31:0] p_nxt [3];
  logic [15:0] dt_r, dt_nxt;
  logic        kj_r, kj_nxt, gnd_r, gnd_nxt, jwh_r, jwh_nxt, jumped_r, jumped_nxt;
  logic [31:0] div_r, div_nxt;       // length of wish vector, then speed
  logic [31:0] a_r, a_nxt;           // friction k, then accel term
  logic [31:0] ns_r, ns_nxt;
  logic [31:0] as_r, as_nxt;
  logic signed [39:0] add_r, add_nxt;

  logic               out_valid_r, out_valid_nxt, out_jumped_r, out_jumped_nxt;
  logic signed [31:0] out_p_r [3];
  logic signed [31:0] out_p_nxt [3];
  logic signed [31:0] out_v_r [3];
  logic signed [31:0] out_v_nxt [3];

  // shared units
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_r;
  ds_req_t            ds_req;
  logic [63:0]        ds_a;
  logic [31:0]        ds_b, ds_res;
  logic               ds_done;

  pmps_mul u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  pmps_divsqrt u_ds (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (ds_req),
    .opa   (ds_a),
    .opb   (ds_b),
    .done  (ds_done),
    .res   (ds_res)
  );

  // wish direction from the keys, opposed keys cancel
  logic signed [17:0] fx, fz, rx, ry, rz, wish0, wish1, wish2;
  always_comb begin
    fx = 18'(in_fwd_x);
    fz = 18'(in_fwd_z);
    rx = 18'(in_side_x);
    ry = 18'(in_side_y);
    rz = 18'(in_side_z);
    wish0 = (in_key_forward ? fx : 18'sd0) - (in_key_back ? fx : 18'sd0)
          + (in_key_right ? rx : 18'sd0) - (in_key_left ? rx : 18'sd0);
    wish1 = (in_key_right ? ry : 18'sd0) - (in_key_left ? ry : 18'sd0);
    wish2 = (in_key_forward ? fz : 18'sd0) - (in_key_back ? fz : 18'sd0)
          + (in_key_right ? rz : 18'sd0) - (in_key_left ? rz : 18'sd0);
  end

  logic signed [65:0] sum, cur, add_w;
  logic signed [32:0] vsel, vabs, wsel, wabs;
  logic [39:0]        drop;
  logic [31:0]        asf;
  logic               last;

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    ph_nxt     = ph_r;
    acc_nxt    = acc_r;
    w_nxt      = w_r;
    v_nxt      = v_r;
    p_nxt      = p_r;
    dt_nxt     = dt_r;
    kj_nxt     = kj_r;
    gnd_nxt    = gnd_r;
    jwh_nxt    = jwh_r;
    jumped_nxt = jumped_r;
    div_nxt    = div_r;
    a_nxt      = a_r;
    ns_nxt     = ns_r;
    as_nxt     = as_r;
    add_nxt    = add_r;
    out_p_nxt  = out_p_r;
    out_v_nxt  = out_v_r;
    out_jumped_nxt = out_jumped_r;
    out_valid_nxt  = out_valid_r & out_stall;
    mul_a  = '0;
    mul_b  = '0;
    ds_req = '0;
    ds_a   = '0;
    ds_b   = '0;

    sum   = acc_r + prod_r;
    last  = (idx_r == 2'd2);
    vsel  = 33'(v_r[idx_r]);
    vabs  = vsel[32] ? -vsel : vsel;
    wsel  = 33'(w_r[idx_r]);
    wabs  = wsel[32] ? -wsel : wsel;
    drop  = prod_r[55:16];
    asf   = prod_r[47:16];
    cur   = trunc_shr(sum, 14);
    add_w = $signed({42'd0, max_speed_r}) - cur;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          w_nxt[0] = wish0;
          w_nxt[1] = wish1;
          w_nxt[2] = wish2;
          dt_nxt   = in_time_step;
          kj_nxt   = in_key_jump;
          gnd_nxt  = in_grounded;
          acc_nxt  = '0;
          idx_nxt  = '0;
          ph_nxt   = '0;
          state_nxt = S_L2;
        end
      end
      // squared length of the wish vector
      S_L2: begin
        mul_a = wsel;
        mul_b = wsel;
        if (ph_r == 2'd0) begin
          ph_nxt = 2'd1;
        end else begin
          ph_nxt  = 2'd0;
          acc_nxt = sum;
          idx_nxt = idx_r + 2'd1;
          if (last) begin
            idx_nxt = '0;
            if (sum > L2_MIN) begin
              state_nxt = S_LEN;
            end else if (gnd_r) begin
              acc_nxt   = '0;
              state_nxt = S_VSQ;
            end else begin
              state_nxt = S_GRAV;
            end
          end
        end
      end
      S_LEN: begin
        ds_a = acc_r[63:0];
        if (ph_r == 2'd0) begin
          ds_req.start   = 1'b1;
          ds_req.is_sqrt = 1'b1;
          ph_nxt = 2'd1;
        end else if (ds_done) begin
          div_nxt   = ds_res;
          ph_nxt    = 2'd0;
          state_nxt = S_NRM;
        end
      end
      // each component times 2^14 over the length
      S_NRM: begin
        ds_a = 64'(wabs) << 14;
        ds_b = div_r;
        if (ph_r == 2'd0) begin
          ds_req.start = 1'b1;
          ph_nxt = 2'd1;
        end else if (ds_done) begin
          w_nxt[idx_r] = wsel[32] ? -18'(ds_res) : 18'(ds_res);
          ph_nxt  = 2'd0;
          idx_nxt = idx_r + 2'd1;
          if (last) begin
            idx_nxt = '0;
            if (gnd_r) begin
              acc_nxt   = '0;
              state_nxt = S_VSQ;
            end else begin
              state_nxt = S_GRAV;
            end
          end
        end
      end
      // squared speed for friction
      S_VSQ: begin
        mul_a = vsel;
        mul_b = vsel;
        if (ph_r == 2'd0) begin
          ph_nxt = 2'd1;
        end else begin
          ph_nxt  = 2'd0;
          acc_nxt = sum;
          idx_nxt = idx_r + 2'd1;
          if (last) begin
            idx_nxt = '0;
            if (sum > S2_MIN) begin
              state_nxt = S_SPD;
            end else begin
              acc_nxt   = '0;
              state_nxt = S_DOT;
            end
          end
        end
      end
      S_SPD: begin
        ds_a = acc_r[63:0];
        if (ph_r == 2'd0) begin
          ds_req.start   = 1'b1;
          ds_req.is_sqrt = 1'b1;
          ph_nxt = 2'd1;
        end else if (ds_done) begin
          div_nxt   = ds_res;
          ph_nxt    = 2'd0;
          state_nxt = S_K;
        end
      end
      S_K: begin
        mul_a = 33'(friction_r);
        mul_b = 33'(dt_r);
        if (ph_r == 2'd0) begin
          ph_nxt = 2'd1;
        end else begin
          a_nxt     = {8'd0, prod_r[39:16]};
          ph_nxt    = 2'd0;
          state_nxt = S_DROP;
        end
      end
      S_DROP: begin
        mul_a = 33'(div_r);
        mul_b = 33'(a_r);
        if (ph_r == 2'd0) begin
          ph_nxt = 2'd1;
        end else begin
          ns_nxt    = (drop >= {8'd0, div_r}) ? 32'd0 : div_r - drop[31:0];
          ph_nxt    = 2'd0;
          state_nxt = S_SCL;
        end
      end
      // each component scaled by new speed over speed
      S_SCL: begin
        mul_a = vabs;
        mul_b = 33'(ns_r);
        ds_a  = prod_r[63:0];
        ds_b  = div_r;
        if (ph_r == 2'd0) begin
          ph_nxt = 2'd1;
        end else if (ph_r == 2'd1) begin
          ds_req.start = 1'b1;
          ph_nxt = 2'd2;
        end else if (ds_done) begin
          v_nxt[idx_r] = vsel[32] ? -ds_res : ds_res;
          ph_nxt  = 2'd0;
          idx_nxt = idx_r + 2'd1;
          if (last) begin
            idx_nxt   = '0;
            acc_nxt   = '0;
            state_nxt = S_DOT;
          end
        end
      end
      S_GRAV: begin
        mul_a = 33'(gravity_r);
        mul_b = 33'(dt_r);
        if (ph_r == 2'd0) begin
          ph_nxt = 2'd1;
        end else begin
          v_nxt[1]  = sat32(66'(v_r[1]) - (prod_r >>> 16));
          ph_nxt    = 2'd0;
          acc_nxt   = '0;
          state_nxt = S_DOT;
        end
      end
      // current speed along the wish direction
      S_DOT: begin
        mul_a = wsel;
        mul_b = vsel;
        if (ph_r == 2'd0) begin
          ph_nxt = 2'd1;
        end else begin
          ph_nxt  = 2'd0;
          acc_nxt = sum;
          idx_nxt = idx_r + 2'd1;
          if (last) begin
            idx_nxt = '0;
            add_nxt = 40'(add_w);
            state_nxt = (add_w > 66'sd0) ? S_A : S_JMP;
          end
        end
      end
      S_A: begin
        mul_a = 33'(gnd_r ? ground_accel_r : air_accel_r);
        mul_b = 33'(max_speed_r);
        if (ph_r == 2'd0) begin
          ph_nxt = 2'd1;
        end else begin
          a_nxt     = prod_r[47:16];
          ph_nxt    = 2'd0;
          state_nxt = S_AS;
        end
      end
      S_AS: begin
        mul_a = 33'(a_r);
        mul_b = 33'(dt_r);
        if (ph_r == 2'd0) begin
          ph_nxt = 2'd1;
        end else begin
          as_nxt    = (add_r < $signed({8'd0, asf})) ? add_r[31:0] : asf;
          ph_nxt    = 2'd0;
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        mul_a = wsel;
        mul_b = 33'(as_r);
        if (ph_r == 2'd0) begin
          ph_nxt = 2'd1;
        end else begin
          v_nxt[idx_r] = sat32(66'(v_r[idx_r]) + trunc_shr(prod_r, 14));
          ph_nxt  = 2'd0;
          idx_nxt = idx_r + 2'd1;
          if (last) begin
            idx_nxt   = '0;
            state_nxt = S_JMP;
          end
        end
      end
      // jump fires on the rising edge of the key, edge memory only on ground
      S_JMP: begin
        jumped_nxt = gnd_r & kj_r & ~jwh_r;
        if (gnd_r) begin
          jwh_nxt = kj_r;
          if (kj_r && !jwh_r) begin
            v_nxt[1] = $signed({8'd0, jump_speed_r});
          end
        end
        idx_nxt   = '0;
        ph_nxt    = '0;
        state_nxt = S_INT;
      end
      S_INT: begin
        mul_a = vsel;
        mul_b = 33'(dt_r);
        if (ph_r == 2'd0) begin
          ph_nxt = 2'd1;
        end else begin
          p_nxt[idx_r] = sat32(66'(p_r[idx_r]) + trunc_shr(prod_r, 16));
          ph_nxt  = 2'd0;
          idx_nxt = idx_r + 2'd1;
          if (last) begin
            idx_nxt   = '0;
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_p_nxt      = p_r;
          out_v_nxt      = v_r;
          out_jumped_nxt = jumped_r;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      ph_r        <= '0;
      v_r         <= '{default: '0};
      p_r         <= '{default: '0};
      jwh_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      ph_r        <= ph_nxt;
      v_r         <= v_nxt;
      p_r         <= p_nxt;
      jwh_r       <= jwh_nxt;
      out_valid_r <= out_valid_nxt;
    end
    acc_r        <= acc_nxt;
    w_r          <= w_nxt;
    dt_r         <= dt_nxt;
    kj_r         <= kj_nxt;
    gnd_r        <= gnd_nxt;
    jumped_r     <= jumped_nxt;
    div_r        <= div_nxt;
    a_r          <= a_nxt;
    ns_r         <= ns_nxt;
    as_r         <= as_nxt;
    add_r        <= add_nxt;
    out_p_r      <= out_p_nxt;
    out_v_r      <= out_v_nxt;
    out_jumped_r <= out_jumped_nxt;
  end

  assign in_stall   = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_pos_x  = out_p_r[0];
  assign out_pos_y  = out_p_r[1];
  assign out_pos_z  = out_p_r[2];
  assign out_vel_x  = out_v_r[0];
  assign out_vel_y  = out_v_r[1];
  assign out_vel_z  = out_v_r[2];
  assign out_jumped = out_jumped_r;

endmodule

// File: rtl/core/pmps_checker.sv
// Port-level checker for the player movement step, bound to the top level.
module pmps_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] out_vel_y,
  input logic               out_jumped
);

  // one item in work at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item was in work");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown after reset");

  // a jump sets vertical velocity to an unsigned value
  a_jump_up: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_jumped |-> !out_vel_y[31])
    else $error("jump with downward velocity");

endmodule

bind player_movement_physics_step pmps_checker u_pmps_checker (.*);
